/* hdl/cia_pkg.sv */
// shared types and constants of the checked int32 alu
package cia_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned WIDE_W   = 2 * DATA_W;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned DIV_CELLS = DATA_W;

  localparam logic [KIND_W-1:0] KIND_NEG = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REM = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_OVER  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_MOD0  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_div;
    logic              neg_q;
    logic              neg_r;
    logic [ERR_W-1:0]  pre_err;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] dvsr;
  } lane_t;

endpackage

/* hdl/cia_front.sv */
// entry stage: operand decode, negate/add/sub/multiply and divider setup
module cia_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cia_pkg::KIND_W-1:0]     in_kind,
  input  logic signed [cia_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [cia_pkg::DATA_W-1:0] in_operand_b,
  output logic                           nx_valid,
  input  logic                           nx_ready,
  output cia_pkg::lane_t                 nx_lane
);

  logic                                  valid_r;
  cia_pkg::lane_t                        lane_r;
  cia_pkg::lane_t                        lane_nxt;
  logic signed [cia_pkg::WIDE_W-1:0]     a_w;
  logic signed [cia_pkg::WIDE_W-1:0]     b_w;
  logic signed [cia_pkg::WIDE_W-1:0]     prod;
  logic signed [cia_pkg::WIDE_W-1:0]     wide;
  logic [cia_pkg::DATA_W-1:0]            mag_a;
  logic [cia_pkg::DATA_W-1:0]            mag_b;

  assign a_w   = cia_pkg::WIDE_W'(in_operand_a);
  assign b_w   = cia_pkg::WIDE_W'(in_operand_b);
  assign prod  = in_operand_a * in_operand_b;
  assign mag_a = in_operand_a[cia_pkg::DATA_W-1] ? -in_operand_a : in_operand_a;
  assign mag_b = in_operand_b[cia_pkg::DATA_W-1] ? -in_operand_b : in_operand_b;

  always_comb begin
    lane_nxt         = '0;
    lane_nxt.kind    = in_kind;
    lane_nxt.neg_q   = in_operand_a[cia_pkg::DATA_W-1] ^ in_operand_b[cia_pkg::DATA_W-1];
    lane_nxt.neg_r   = in_operand_a[cia_pkg::DATA_W-1];
    lane_nxt.dvsr    = mag_b;
    lane_nxt.pre_err = cia_pkg::ERR_OK;
    wide             = '0;
    unique case (in_kind)
      cia_pkg::KIND_NEG: wide = -a_w;
      cia_pkg::KIND_ADD: wide = a_w + b_w;
      cia_pkg::KIND_SUB: wide = a_w - b_w;
      cia_pkg::KIND_MUL: wide = prod;
      cia_pkg::KIND_DIV, cia_pkg::KIND_REM: begin
        lane_nxt.is_div = 1'b1;
        if (in_operand_b == '0) begin
          lane_nxt.pre_err = (in_kind == cia_pkg::KIND_DIV) ? cia_pkg::ERR_DIV0
                                                             : cia_pkg::ERR_MOD0;
        end
      end
      default: wide = '0;
    endcase
    if (lane_nxt.is_div) begin
      lane_nxt.hi = '0;
      lane_nxt.lo = mag_a;
    end else begin
      lane_nxt.hi = wide[cia_pkg::WIDE_W-1:cia_pkg::DATA_W];
      lane_nxt.lo = wide[cia_pkg::DATA_W-1:0];
    end
  end

  assign in_ready = !valid_r || nx_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      lane_r <= lane_nxt;
    end
  end

  assign nx_valid = valid_r;
  assign nx_lane  = lane_r;

endmodule

/* hdl/cia_div_cell.sv */
// one restoring divide cell: one quotient bit per transaction
module cia_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pv_valid,
  output logic           pv_ready,
  input  cia_pkg::lane_t pv_lane,
  output logic           nx_valid,
  input  logic           nx_ready,
  output cia_pkg::lane_t nx_lane
);

  logic                        valid_r;
  cia_pkg::lane_t              lane_r;
  cia_pkg::lane_t              lane_nxt;
  logic [cia_pkg::DATA_W:0]    trial;
  logic [cia_pkg::DATA_W:0]    diff;
  logic                        ge;

  assign trial = {pv_lane.hi, pv_lane.lo[cia_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, pv_lane.dvsr};
  assign ge    = trial >= {1'b0, pv_lane.dvsr};

  always_comb begin
    lane_nxt = pv_lane;
    if (pv_lane.is_div) begin
      lane_nxt.hi = ge ? diff[cia_pkg::DATA_W-1:0] : trial[cia_pkg::DATA_W-1:0];
      lane_nxt.lo = {pv_lane.lo[cia_pkg::DATA_W-2:0], ge};
    end
  end

  assign pv_ready = !valid_r || nx_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pv_ready) begin
      valid_r <= pv_valid;
    end
    if (pv_ready && pv_valid) begin
      lane_r <= lane_nxt;
    end
  end

  assign nx_valid = valid_r;
  assign nx_lane  = lane_r;

endmodule

/* hdl/cia_back.sv */
// exit stage: sign fix-up, range check and output register
module cia_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pv_valid,
  output logic                          pv_ready,
  input  cia_pkg::lane_t                pv_lane,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cia_pkg::DATA_W-1:0] out_result_value,
  output logic [cia_pkg::ERR_W-1:0]     out_error_code
);

  logic                                 valid_r;
  logic [cia_pkg::DATA_W-1:0]           value_r;
  logic [cia_pkg::DATA_W-1:0]           value_nxt;
  logic [cia_pkg::ERR_W-1:0]            err_r;
  logic [cia_pkg::ERR_W-1:0]            err_nxt;
  logic [cia_pkg::DATA_W-1:0]           mag;
  logic                                 neg;
  logic [cia_pkg::WIDE_W-1:0]           mag_w;
  logic [cia_pkg::WIDE_W-1:0]           wide;
  logic [cia_pkg::DATA_W:0]             top;
  logic                                 over;
  logic                                 under;

  always_comb begin
    if (pv_lane.kind == cia_pkg::KIND_REM) begin
      mag = pv_lane.hi;
      neg = pv_lane.neg_r;
    end else begin
      mag = pv_lane.lo;
      neg = pv_lane.neg_q;
    end
    mag_w = {{cia_pkg::DATA_W{1'b0}}, mag};
    if (pv_lane.is_div) begin
      wide = neg ? -mag_w : mag_w;
    end else begin
      wide = {pv_lane.hi, pv_lane.lo};
    end
    top   = wide[cia_pkg::WIDE_W-1:cia_pkg::DATA_W-1];
    over  = !top[cia_pkg::DATA_W] && (top != '0);
    under = top[cia_pkg::DATA_W] && (top != '1);
    priority if (pv_lane.pre_err != cia_pkg::ERR_OK) begin
      err_nxt = pv_lane.pre_err;
    end else if (over) begin
      err_nxt = cia_pkg::ERR_OVER;
    end else if (under) begin
      err_nxt = cia_pkg::ERR_UNDER;
    end else begin
      err_nxt = cia_pkg::ERR_OK;
    end
    value_nxt = (err_nxt == cia_pkg::ERR_OK) ? wide[cia_pkg::DATA_W-1:0] : '0;
  end

  assign pv_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pv_ready) begin
      valid_r <= pv_valid;
    end
    if (pv_ready && pv_valid) begin
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_value = value_r;
  assign out_error_code   = err_r;

endmodule

/* hdl/checked_int32_alu_core.sv */
// top level of the overflow checked int32 alu
// Takes one transaction per clock while in_ready is high and returns one
// result per transaction, in order. Every operation passes through the same
// stages: an entry stage (add, subtract, negate and the 32x32 multiply), a
// chain of 32 restoring divide cells that each produce one quotient bit, and
// an exit stage that fixes signs, checks the 32-bit range and holds the
// result. Every stage has its own valid bit and takes new data whenever the
// stage after it is empty or moving, so gaps in the chain close up while a
// finished result waits at the output.
module checked_int32_alu_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cia_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [cia_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [cia_pkg::DATA_W-1:0] in_operand_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cia_pkg::DATA_W-1:0] out_result_value,
  output logic [cia_pkg::ERR_W-1:0]         out_error_code
);

  logic           st_valid [0:cia_pkg::DIV_CELLS];
  logic           st_ready [0:cia_pkg::DIV_CELLS];
  cia_pkg::lane_t st_lane  [0:cia_pkg::DIV_CELLS];

  cia_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .nx_valid     (st_valid[0]),
    .nx_ready     (st_ready[0]),
    .nx_lane      (st_lane[0])
  );

  for (genvar i = 0; i < cia_pkg::DIV_CELLS; i++) begin : g_cell
    cia_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pv_valid (st_valid[i]),
      .pv_ready (st_ready[i]),
      .pv_lane  (st_lane[i]),
      .nx_valid (st_valid[i+1]),
      .nx_ready (st_ready[i+1]),
      .nx_lane  (st_lane[i+1])
    );
  end

  cia_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pv_valid         (st_valid[cia_pkg::DIV_CELLS]),
    .pv_ready         (st_ready[cia_pkg::DIV_CELLS]),
    .pv_lane          (st_lane[cia_pkg::DIV_CELLS]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code)
  );

endmodule

/* tb/checked_int32_alu_core_tb.sv */
// testbench for checked_int32_alu_core: directed and random operations against a local predictor
`timescale 1ns / 1ps

module checked_int32_alu_core_tb;

  localparam logic [cia_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [cia_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam logic signed [cia_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [cia_pkg::DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam longint WIDE_MAX = 64'sd2147483647;
  localparam longint WIDE_MIN = -64'sd2147483648;
  localparam int IDLE_PCT = 18;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [cia_pkg::DATA_W-1:0] value;
    logic [cia_pkg::ERR_W-1:0]         err;
  } alu_result_t;

  typedef struct packed {
    logic [cia_pkg::KIND_W-1:0]        kind;
    logic signed [cia_pkg::DATA_W-1:0] a;
    logic signed [cia_pkg::DATA_W-1:0] b;
    alu_result_t                       res;
  } alu_expect_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [cia_pkg::KIND_W-1:0]        in_kind = '0;
  logic signed [cia_pkg::DATA_W-1:0] in_operand_a = '0;
  logic signed [cia_pkg::DATA_W-1:0] in_operand_b = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [cia_pkg::DATA_W-1:0] out_result_value;
  logic [cia_pkg::ERR_W-1:0]         out_error_code;

  alu_expect_t pending_results[$];
  int          fail_count = 0;
  bit          steady = 1'b0;

  checked_int32_alu_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [cia_pkg::ERR_W-1:0] range_err(longint exact);
    if (exact > WIDE_MAX) return cia_pkg::ERR_OVER;
    if (exact < WIDE_MIN) return cia_pkg::ERR_UNDER;
    return cia_pkg::ERR_OK;
  endfunction

  function automatic alu_result_t predict_checked(logic [cia_pkg::KIND_W-1:0] kind,
                                                  logic signed [cia_pkg::DATA_W-1:0] a,
                                                  logic signed [cia_pkg::DATA_W-1:0] b);
    longint                    wa;
    longint                    wb;
    longint                    exact;
    logic [cia_pkg::ERR_W-1:0] err;
    alu_result_t               res;
    wa = a;
    wb = b;
    exact = 0;
    err = cia_pkg::ERR_OK;
    case (kind)
      cia_pkg::KIND_NEG: begin
        if (a == INT_MIN) err = cia_pkg::ERR_OVER;
        else exact = -wa;
      end
      cia_pkg::KIND_ADD: begin
        exact = wa + wb;
        err = range_err(exact);
      end
      cia_pkg::KIND_SUB: begin
        exact = wa - wb;
        err = range_err(exact);
      end
      cia_pkg::KIND_MUL: begin
        exact = wa * wb;
        err = range_err(exact);
      end
      cia_pkg::KIND_DIV: begin
        if (b == 0) err = cia_pkg::ERR_DIV0;
        else if (a == INT_MIN && b == -1) err = cia_pkg::ERR_OVER;
        else exact = wa / wb;
      end
      cia_pkg::KIND_REM: begin
        if (b == 0) err = cia_pkg::ERR_MOD0;
        else exact = wa % wb;
      end
      default: exact = 0;
    endcase
    if (err != cia_pkg::ERR_OK) exact = 0;
    res.value = exact[cia_pkg::DATA_W-1:0];
    res.err = err;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // one transaction on the input side, optionally preceded by an idle gap
  task automatic send_op(logic [cia_pkg::KIND_W-1:0] kind,
                         logic signed [cia_pkg::DATA_W-1:0] a,
                         logic signed [cia_pkg::DATA_W-1:0] b);
    alu_expect_t item;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    item.kind = kind;
    item.a = a;
    item.b = b;
    item.res = predict_checked(kind, a, b);
    pending_results.push_back(item);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [cia_pkg::DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return 0;
      3: return -1;
      4: return 1;
      5: return $signed($urandom_range(0, 200)) - 100;
      6: return $signed({{16{$urandom_range(0, 1) == 1}}, 16'($urandom)});
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [cia_pkg::KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 19) == 0)
      return cia_pkg::KIND_W'($urandom_range(KIND_SPARE6, KIND_SPARE7));
    return cia_pkg::KIND_W'($urandom_range(cia_pkg::KIND_NEG, cia_pkg::KIND_REM));
  endfunction

  // output side stalls at random unless the steady stretch is running
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    alu_expect_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction value=%0d err=%0d",
                                  out_result_value, out_error_code));
      end else begin
        head = pending_results.pop_front();
        if (out_result_value !== head.res.value)
          report_mismatch($sformatf("kind=%0d a=%0d b=%0d value got %0d want %0d",
                                    head.kind, head.a, head.b,
                                    out_result_value, head.res.value));
        if (out_error_code !== head.res.err)
          report_mismatch($sformatf("kind=%0d a=%0d b=%0d err got %0d want %0d",
                                    head.kind, head.a, head.b,
                                    out_error_code, head.res.err));
      end
    end
  end

  task automatic test_range_extremes();
    send_op(cia_pkg::KIND_NEG, INT_MAX, 0);
    send_op(cia_pkg::KIND_NEG, 0, INT_MIN);
    send_op(cia_pkg::KIND_ADD, INT_MAX, 1);
    send_op(cia_pkg::KIND_ADD, INT_MIN, -1);
    send_op(cia_pkg::KIND_ADD, INT_MAX, INT_MIN);
    send_op(cia_pkg::KIND_SUB, INT_MIN, 1);
    send_op(cia_pkg::KIND_SUB, INT_MAX, -1);
    send_op(cia_pkg::KIND_SUB, 0, INT_MIN);
    send_op(cia_pkg::KIND_MUL, INT_MIN, INT_MIN);
    send_op(cia_pkg::KIND_MUL, INT_MAX, INT_MIN);
    send_op(cia_pkg::KIND_MUL, INT_MIN, 1);
    send_op(cia_pkg::KIND_MUL, -65536, 32768);
    send_op(cia_pkg::KIND_DIV, INT_MIN, 1);
    send_op(cia_pkg::KIND_DIV, -7, 2);
    send_op(cia_pkg::KIND_REM, -7, 2);
    send_op(cia_pkg::KIND_REM, 7, -2);
  endtask

  task automatic test_special_cases();
    send_op(cia_pkg::KIND_NEG, INT_MIN, -1);
    send_op(cia_pkg::KIND_DIV, INT_MIN, -1);
    send_op(cia_pkg::KIND_MUL, INT_MIN, -1);
    send_op(cia_pkg::KIND_REM, INT_MIN, -1);
    send_op(cia_pkg::KIND_DIV, 7, 0);
    send_op(cia_pkg::KIND_REM, 5, 0);
    send_op(KIND_SPARE6, -1, -1);
    send_op(KIND_SPARE7, INT_MIN, INT_MAX);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_op(pick_kind(), pick_operand(), pick_operand());
  endtask

  task automatic test_no_idle_stretch(int count);
    steady = 1'b1;
    test_random_mix(count);
    steady = 1'b0;
  endtask

  task automatic test_drain_between_bursts();
    repeat (4) begin
      test_random_mix(25);
      wait_all_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_range_extremes();
    test_special_cases();
    test_random_mix(300);
    test_no_idle_stretch(150);
    test_drain_between_bursts();
    test_random_mix(200);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/cia_pkg.sv
hdl/cia_front.sv
hdl/cia_div_cell.sv
hdl/cia_back.sv
hdl/checked_int32_alu_core.sv
tb/checked_int32_alu_core_tb.sv
